>>> sv/js3d_pkg.sv
// Shared types and constants for the 3D Jacobi stencil sweep block.
// Used by the channel interface users and by jacobi_stencil_3d_sweep.
`default_nettype none

package js3d_pkg;

  localparam int MAX_PADDED_SIDE_DEF = 64;
  localparam int COORD_W             = 6;

  typedef logic signed [31:0] q824_t;
  typedef logic [30:0]        uq824_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SIZE_I   = 3'd0,
    CFG_SIZE_J   = 3'd1,
    CFG_SIZE_K   = 3'd2,
    CFG_LO_FLAGS = 3'd3,
    CFG_HI_FLAGS = 3'd4,
    CFG_SOURCE   = 3'd5
  } cfg_idx_t;

  localparam logic [5:0]  SIZE_RST   = 6'd60;
  localparam logic [2:0]  FLAGS_RST  = 3'd7;
  localparam uq824_t      SOURCE_RST = 31'd4660;

  localparam q824_t       Q_MAX      = 32'sh7fff_ffff;
  localparam q824_t       Q_MIN      = 32'sh8000_0000;
  localparam uq824_t      D31_MAX    = 31'h7fff_ffff;

  // Rounded magnitude at or above 6 * 2^31 gives a quotient that saturates.
  localparam logic [33:0] SAT_LIMIT  = 34'd12884901888;
  // ceil(2^34 / 3): exact floor(x / 3) for any x below 2^33 after >> 34.
  localparam logic [32:0] RECIP3     = 33'd5726623062;

  typedef struct packed {
    q824_t old_value;
  } in_word_t;

  typedef struct packed {
    q824_t  new_value;
    coord_t out_i;
    coord_t out_j;
    coord_t out_k;
    uq824_t max_delta;
    logic   is_last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_word_t;

  // Control that travels with each word down the arithmetic pipeline.
  typedef struct packed {
    logic   emit;
    logic   wrap;
    logic   last;
    coord_t ci;
    coord_t cj;
    coord_t ck;
  } tag_t;

endpackage

`default_nettype wire

>>> sv/js3d_chan_if.sv
// Valid/ready channel carrying one payload word of a chosen type.
// Payload types come from js3d_pkg at the point of instantiation.
`default_nettype none

interface js3d_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/jacobi_stencil_3d_sweep.sv
// One Jacobi sweep of the 7-point 3D Poisson stencil over a raster-ordered padded grid.
// Depends on js3d_pkg and js3d_chan_if. One word per cycle is sustained while out_chan
// accepts results, set by the 8-stage arithmetic pipeline and three replicated two-read
// window memories. Reset clears position, running maximum, pipeline and configuration;
// the window store is not cleared.
`default_nettype none

module jacobi_stencil_3d_sweep
  import js3d_pkg::*;
#(
  parameter int MAX_PADDED_SIDE = MAX_PADDED_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  js3d_chan_if.sink   in_chan,
  js3d_chan_if.source out_chan,
  js3d_chan_if.sink   cfg_chan
);

  // Size registers are 6 bits, so no side ever exceeds 65.
  localparam int SIDE_MAX  = (MAX_PADDED_SIDE < 65) ? MAX_PADDED_SIDE : 65;
  localparam int EFF_MAX   = SIDE_MAX - 2;
  localparam int CW        = $clog2(SIDE_MAX);
  localparam int SW        = $clog2(SIDE_MAX + 1);
  localparam int WIN_DEPTH = 2 * MAX_PADDED_SIDE * MAX_PADDED_SIDE;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int NS        = 8;
  localparam int N_COPY    = 3;

  // ---------------------------------------------------------------- config
  logic [5:0]  size_r [3];
  logic [2:0]  lo_flags_r;
  logic [2:0]  hi_flags_r;
  uq824_t      source_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0]  <= SIZE_RST;
      size_r[1]  <= SIZE_RST;
      size_r[2]  <= SIZE_RST;
      lo_flags_r <= FLAGS_RST;
      hi_flags_r <= FLAGS_RST;
      source_r   <= SOURCE_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.data.index)
        CFG_SIZE_I:   size_r[0]  <= cfg_chan.data.value[5:0];
        CFG_SIZE_J:   size_r[1]  <= cfg_chan.data.value[5:0];
        CFG_SIZE_K:   size_r[2]  <= cfg_chan.data.value[5:0];
        CFG_LO_FLAGS: lo_flags_r <= cfg_chan.data.value[2:0];
        CFG_HI_FLAGS: hi_flags_r <= cfg_chan.data.value[2:0];
        CFG_SOURCE:   source_r   <= cfg_chan.data.value[30:0];
        default: begin
        end
      endcase
    end
  end

  logic [5:0]    eff [3];
  logic [SW-1:0] side [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      eff[a]  = (size_r[a] > 6'(EFF_MAX)) ? 6'(EFF_MAX) : size_r[a];
      side[a] = SW'(eff[a]) + SW'(2);
    end
  end

  // ------------------------------------------------------ raster position
  logic [CW-1:0] pos_r   [3];
  logic [CW-1:0] pos_nxt [3];
  logic          k_end, j_end, i_end, wrap_now;
  logic          accept;
  logic [NS:1]   free;

  assign in_chan.ready = free[1];
  assign accept        = in_chan.valid && free[1];

  always_comb begin
    pos_nxt  = pos_r;
    k_end    = (SW'(pos_r[2]) + SW'(1)) >= side[2];
    j_end    = (SW'(pos_r[1]) + SW'(1)) >= side[1];
    i_end    = (SW'(pos_r[0]) + SW'(1)) >= side[0];
    wrap_now = k_end && j_end && i_end;
    if (!k_end) begin
      pos_nxt[2] = pos_r[2] + 1'b1;
    end else begin
      pos_nxt[2] = '0;
      if (!j_end) begin
        pos_nxt[1] = pos_r[1] + 1'b1;
      end else begin
        pos_nxt[1] = '0;
        pos_nxt[0] = i_end ? '0 : pos_r[0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // ------------------------------------------------ bounds of the update
  function automatic logic axis_ok(logic [CW-1:0] c, logic lo_f, logic hi_f, logic [5:0] e);
    logic [SW-1:0] cc;
    cc = SW'(c);
    return (cc >= (lo_f ? SW'(2) : SW'(1))) && ((cc + SW'(hi_f)) <= SW'(e));
  endfunction

  function automatic logic axis_last(logic [CW-1:0] c, logic hi_f, logic [5:0] e);
    return (SW'(c) + SW'(hi_f)) == SW'(e);
  endfunction

  logic [CW-1:0] ci_c;
  tag_t          tag0;

  always_comb begin
    ci_c      = pos_r[0] - 1'b1;
    tag0.emit = (pos_r[0] != '0)
                && axis_ok(ci_c,     lo_flags_r[0], hi_flags_r[0], eff[0])
                && axis_ok(pos_r[1], lo_flags_r[1], hi_flags_r[1], eff[1])
                && axis_ok(pos_r[2], lo_flags_r[2], hi_flags_r[2], eff[2]);
    tag0.last = axis_last(ci_c,     hi_flags_r[0], eff[0])
                && axis_last(pos_r[1], hi_flags_r[1], eff[1])
                && axis_last(pos_r[2], hi_flags_r[2], eff[2]);
    tag0.wrap = wrap_now;
    tag0.ci   = COORD_W'(ci_c);
    tag0.cj   = COORD_W'(pos_r[1]);
    tag0.ck   = COORD_W'(pos_r[2]);
  end

  // --------------------------------------------------------- window store
  // The two most recent planes live at (plane parity, j, k). Three copies share
  // every write so that six taps can be read in the same cycle. Reads are read-first,
  // so the tap at the write address returns the plane two back.
  function automatic logic [AW-1:0] win_addr(logic par, logic [CW-1:0] j, logic [CW-1:0] k);
    return AW'(par) * AW'(MAX_PADDED_SIDE * MAX_PADDED_SIDE)
           + AW'(j) * AW'(MAX_PADDED_SIDE) + AW'(k);
  endfunction

  logic          par_cur, par_prev;
  logic [AW-1:0] rd_addr [2*N_COPY];
  q824_t         rd_q    [2*N_COPY];

  always_comb begin
    par_cur    = pos_r[0][0];
    par_prev   = ~par_cur;
    rd_addr[0] = win_addr(par_cur,  pos_r[1],        pos_r[2]);
    rd_addr[1] = win_addr(par_prev, pos_r[1],        pos_r[2]);
    rd_addr[2] = win_addr(par_prev, pos_r[1] - 1'b1, pos_r[2]);
    rd_addr[3] = win_addr(par_prev, pos_r[1] + 1'b1, pos_r[2]);
    rd_addr[4] = win_addr(par_prev, pos_r[1],        pos_r[2] - 1'b1);
    rd_addr[5] = win_addr(par_prev, pos_r[1],        pos_r[2] + 1'b1);
  end

  for (genvar g = 0; g < N_COPY; g++) begin : g_win
    q824_t win_mem [WIN_DEPTH];
    q824_t rd_a_r;
    q824_t rd_b_r;

    always_ff @(posedge clk) begin
      if (accept) begin
        win_mem[rd_addr[0]] <= in_chan.data.old_value;
      end
      if (free[1]) begin
        rd_a_r <= win_mem[rd_addr[2*g]];
        rd_b_r <= win_mem[rd_addr[2*g+1]];
      end
    end

    assign rd_q[2*g]   = rd_a_r;
    assign rd_q[2*g+1] = rd_b_r;
  end

  // ------------------------------------------------------ pipeline control
  // Each stage holds one word; a stage loads when it is empty or its word moves on.
  logic [NS:1] vld_r;
  tag_t        tag_r [1:NS];
  logic        drain;
  logic        out_valid_r;

  assign drain = !tag_r[NS].emit || !out_valid_r || out_chan.ready;

  always_comb begin
    free[NS] = !vld_r[NS] || drain;
    for (int n = NS - 1; n >= 1; n--) begin
      free[n] = !vld_r[n] || free[n+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (free[1]) vld_r[1] <= accept;
      for (int n = 2; n <= NS; n++) begin
        if (free[n]) vld_r[n] <= vld_r[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[1]) tag_r[1] <= tag0;
    for (int n = 2; n <= NS; n++) begin
      if (free[n]) tag_r[n] <= tag_r[n-1];
    end
  end

  // ------------------------------------------------------------ datapath
  q824_t              v1_r;
  logic signed [33:0] p0_nxt, p1_nxt, p0_r, p1_r;
  q824_t              old2_r, old3_r, old4_r, old5_r, old6_r;
  logic signed [34:0] s3_nxt, s3_r;
  logic [34:0]        a_full;
  logic [33:0]        a_nxt;
  logic               neg4_r, sat4_r, neg5_r, sat5_r;
  logic [32:0]        b4_r;
  logic [65:0]        prod;
  logic [30:0]        q5_r;
  q824_t              nv_nxt, nv6_r, nv7_r, nv8_r;
  logic signed [32:0] d7_nxt, d7_r;
  logic [32:0]        ad;
  uq824_t             d31_nxt, d31_8_r;

  always_comb begin
    // Stage 2: two partial sums of the source term, center plane taps and neighbors.
    p0_nxt = $signed({3'b000, source_r}) + 34'(v1_r) + 34'(rd_q[0]) + 34'(rd_q[2]);
    p1_nxt = 34'(rd_q[3]) + 34'(rd_q[4]) + 34'(rd_q[5]);
    // Stage 3: exact seven-term sum.
    s3_nxt = 35'(p0_r) + 35'(p1_r);
    // Stage 4: |s| + 3 in one add; halving first lets a divide by 3 finish the job.
    a_full = s3_r[34] ? (~s3_r + 35'd4) : (s3_r + 35'd3);
    a_nxt  = a_full[33:0];
    // Stage 5: floor(b / 3) by reciprocal multiply.
    prod   = 66'(b4_r) * 66'(RECIP3);
    // Stage 6: sign and saturation.
    if (sat5_r) begin
      nv_nxt = neg5_r ? Q_MIN : Q_MAX;
    end else begin
      nv_nxt = neg5_r ? (32'sd0 - $signed({1'b0, q5_r})) : $signed({1'b0, q5_r});
    end
    // Stage 7 and 8: change against the old centre value, saturated to 31 bits.
    d7_nxt  = 33'(nv6_r) - 33'(old6_r);
    ad      = d7_r[32] ? (33'd0 - d7_r) : d7_r;
    d31_nxt = (ad > 33'(D31_MAX)) ? D31_MAX : ad[30:0];
  end

  always_ff @(posedge clk) begin
    if (free[1]) v1_r <= in_chan.data.old_value;
    if (free[2]) begin
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      old2_r <= rd_q[1];
    end
    if (free[3]) begin
      s3_r   <= s3_nxt;
      old3_r <= old2_r;
    end
    if (free[4]) begin
      neg4_r <= s3_r[34];
      sat4_r <= a_nxt >= SAT_LIMIT;
      b4_r   <= a_nxt[33:1];
      old4_r <= old3_r;
    end
    if (free[5]) begin
      neg5_r <= neg4_r;
      sat5_r <= sat4_r;
      q5_r   <= prod[64:34];
      old5_r <= old4_r;
    end
    if (free[6]) begin
      nv6_r  <= nv_nxt;
      old6_r <= old5_r;
    end
    if (free[7]) begin
      d7_r  <= d7_nxt;
      nv7_r <= nv6_r;
    end
    if (free[8]) begin
      d31_8_r <= d31_nxt;
      nv8_r   <= nv7_r;
    end
  end

  // ------------------------------------------------- running max and output
  uq824_t    running_max_r;
  uq824_t    max_nxt;
  out_word_t out_r;
  logic      retire;

  assign retire  = vld_r[NS] && drain;
  assign max_nxt = (d31_8_r > running_max_r) ? d31_8_r : running_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_max_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (retire && tag_r[NS].emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // The sweep's last padded word clears the maximum after its own result.
      if (retire) begin
        if (tag_r[NS].wrap) begin
          running_max_r <= '0;
        end else if (tag_r[NS].emit) begin
          running_max_r <= max_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && tag_r[NS].emit) begin
      out_r.new_value <= nv8_r;
      out_r.out_i     <= tag_r[NS].ci;
      out_r.out_j     <= tag_r[NS].cj;
      out_r.out_k     <= tag_r[NS].ck;
      out_r.max_delta <= max_nxt;
      out_r.is_last   <= tag_r[NS].last;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // ------------------------------------------------------------ assertions
  a_wrap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wrap_now) |=> (pos_r[0] == '0 && pos_r[1] == '0 && pos_r[2] == '0))
    else $error("position did not return to the origin after the last padded word");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r[1])
    else $error("accepted word did not enter the first pipeline stage");

  a_wrap_max: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && tag_r[NS].wrap) |=> (running_max_r == '0))
    else $error("running maximum not cleared at the end of the sweep");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.out_i != '0 && out_r.out_j != '0 && out_r.out_k != '0))
    else $error("result reported on a ghost coordinate");

endmodule

`default_nettype wire
